### rtl/lif_pkg.sv
// Package for the LIF spiking network engine.
// Shared constants, sequencer types and fixed-point helpers; no dependencies.
`default_nettype none

package lif_pkg;

    localparam int MAX_NEURONS_DEF  = 64;
    localparam int MAX_SYNAPSES_DEF = 256;
    localparam int MAX_DELAY_DEF    = 32;

    localparam logic [6:0]  RST_NEURON_COUNT  = 7'd64;
    localparam logic [8:0]  RST_SYNAPSE_COUNT = 9'd0;
    localparam logic [15:0] RST_TICK_SCALE    = 16'd655;
    localparam logic [7:0]  RST_REFRACT       = 8'd10;

    localparam logic [1:0] CFG_NEURON_COUNT  = 2'd0;
    localparam logic [1:0] CFG_SYNAPSE_COUNT = 2'd1;
    localparam logic [1:0] CFG_TICK_SCALE    = 2'd2;
    localparam logic [1:0] CFG_REFRACT       = 2'd3;

    typedef enum logic [1:0] {
        ACT_NEURON  = 2'd0,
        ACT_SYNAPSE = 2'd1,
        ACT_STIM    = 2'd2,
        ACT_TICK    = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_SYN_RD,
        ST_SYN_FETCH,
        ST_SYN_UPD,
        ST_NRN_RD,
        ST_NRN_MUL1,
        ST_NRN_MUL2,
        ST_NRN_UPD,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic clr_step;
        logic item_acc;
        logic tick_begin;
        logic syn_rd;
        logic syn_fetch;
        logic syn_upd;
        logic nrn_rd;
        logic nrn_mul1;
        logic nrn_mul2;
        logic nrn_upd;
        logic cnt_rst;
        logic cnt_inc;
        logic fired_clr;
        logic res_item;
        logic res_tick;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic syn_none;
        logic syn_last;
        logic nrn_none;
        logic nrn_last;
    } t_status;

    localparam logic signed [39:0] Q_MAX = 40'sd8388607;
    localparam logic signed [39:0] Q_MIN = -40'sd8388608;

    function automatic logic signed [23:0] sat24(input logic signed [39:0] x);
        logic signed [23:0] r;
        if (x > Q_MAX)      r = 24'sh7fffff;
        else if (x < Q_MIN) r = 24'sh800000;
        else                r = x[23:0];
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/lif_spiking_network_tick.sv
// Top level of the LIF spiking network engine.
// Instantiates lif_ctrl and lif_dp; uses lif_pkg.
`default_nettype none

// An item is taken when i_start is high and o_busy low. For neuron, synapse
// and stimulus words o_busy stays low and their result word is strobed on
// o_valid in the next cycle; such items may follow each other every cycle. A
// tick keeps o_busy high while it walks the S synapses and N neurons in use,
// set by the single read port of the synapse and neuron memories: three steps
// per synapse and four per neuron (read, two multiplies, write back), then a
// done state; its result word is strobed in the cycle in which o_busy falls.
// After reset a clearing pass over max(MAX_SYNAPSES, MAX_NEURONS) entries runs
// with o_busy high; config writes are taken at any time. Each result word is
// valid for one cycle only; the receiver cannot stall it.
module lif_spiking_network_tick #(
    parameter int MAX_NEURONS  = lif_pkg::MAX_NEURONS_DEF,
    parameter int MAX_SYNAPSES = lif_pkg::MAX_SYNAPSES_DEF,
    parameter int MAX_DELAY    = lif_pkg::MAX_DELAY_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    output logic                    o_busy,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_idx,
    input  wire logic [15:0]        i_cfg_data,
    input  wire logic [1:0]         i_action,
    input  wire logic [7:0]         i_index,
    input  wire logic signed [23:0] i_rest_level,
    input  wire logic signed [23:0] i_fire_level,
    input  wire logic [15:0]        i_leak_coeff,
    input  wire logic               i_is_inhibitory,
    input  wire logic [5:0]         i_from_neuron,
    input  wire logic [5:0]         i_to_neuron,
    input  wire logic signed [23:0] i_syn_weight,
    input  wire logic [4:0]         i_syn_delay,
    input  wire logic signed [23:0] i_stimulus,
    output logic                    o_valid,
    output logic [63:0]             o_spike_mask,
    output logic                    o_tick_done
);

    lif_pkg::t_cmd    cmd;
    lif_pkg::t_status status;

    lif_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_action (i_action),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (o_busy)
    );

    lif_dp #(
        .MAX_NEURONS  (MAX_NEURONS),
        .MAX_SYNAPSES (MAX_SYNAPSES),
        .MAX_DELAY    (MAX_DELAY)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_action        (i_action),
        .i_index         (i_index),
        .i_rest_level    (i_rest_level),
        .i_fire_level    (i_fire_level),
        .i_leak_coeff    (i_leak_coeff),
        .i_is_inhibitory (i_is_inhibitory),
        .i_from_neuron   (i_from_neuron),
        .i_to_neuron     (i_to_neuron),
        .i_syn_weight    (i_syn_weight),
        .i_syn_delay     (i_syn_delay),
        .i_stimulus      (i_stimulus),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_spike_mask    (o_spike_mask),
        .o_valid         (o_valid),
        .o_tick_done     (o_tick_done)
    );

endmodule

`default_nettype wire

### rtl/lif_ctrl.sv
// Sequencer for the LIF network engine: item accept, clearing pass, tick walk.
// Depends on lif_pkg; drives lif_dp through t_cmd and reads t_status.
`default_nettype none

module lif_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire logic [1:0]      i_action,
    input  lif_pkg::t_status     i_status,
    output lif_pkg::t_cmd        o_cmd,
    output logic                 o_busy
);

    lif_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= lif_pkg::ST_CLR;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            lif_pkg::ST_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_last) begin
                    o_cmd.cnt_rst = 1'b1;
                    n_state = lif_pkg::ST_IDLE;
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                end
            end
            lif_pkg::ST_IDLE: begin
                if (i_start) begin
                    if (lif_pkg::t_action'(i_action) == lif_pkg::ACT_TICK) begin
                        o_cmd.tick_begin = 1'b1;
                        o_cmd.cnt_rst    = 1'b1;
                        if (!i_status.syn_none) begin
                            n_state = lif_pkg::ST_SYN_RD;
                        end else begin
                            o_cmd.fired_clr = 1'b1;
                            n_state = i_status.nrn_none ? lif_pkg::ST_DONE
                                                        : lif_pkg::ST_NRN_RD;
                        end
                    end else begin
                        o_cmd.item_acc = 1'b1;
                        o_cmd.res_item = 1'b1;
                    end
                end
            end
            lif_pkg::ST_SYN_RD: begin
                o_cmd.syn_rd = 1'b1;
                n_state = lif_pkg::ST_SYN_FETCH;
            end
            lif_pkg::ST_SYN_FETCH: begin
                o_cmd.syn_fetch = 1'b1;
                n_state = lif_pkg::ST_SYN_UPD;
            end
            lif_pkg::ST_SYN_UPD: begin
                o_cmd.syn_upd = 1'b1;
                if (i_status.syn_last) begin
                    o_cmd.cnt_rst   = 1'b1;
                    o_cmd.fired_clr = 1'b1;
                    n_state = i_status.nrn_none ? lif_pkg::ST_DONE : lif_pkg::ST_NRN_RD;
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                    n_state = lif_pkg::ST_SYN_RD;
                end
            end
            lif_pkg::ST_NRN_RD: begin
                o_cmd.nrn_rd = 1'b1;
                n_state = lif_pkg::ST_NRN_MUL1;
            end
            lif_pkg::ST_NRN_MUL1: begin
                o_cmd.nrn_mul1 = 1'b1;
                n_state = lif_pkg::ST_NRN_MUL2;
            end
            lif_pkg::ST_NRN_MUL2: begin
                o_cmd.nrn_mul2 = 1'b1;
                n_state = lif_pkg::ST_NRN_UPD;
            end
            lif_pkg::ST_NRN_UPD: begin
                o_cmd.nrn_upd = 1'b1;
                if (i_status.nrn_last) begin
                    o_cmd.cnt_rst = 1'b1;
                    n_state = lif_pkg::ST_DONE;
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                    n_state = lif_pkg::ST_NRN_RD;
                end
            end
            lif_pkg::ST_DONE: begin
                o_cmd.res_tick = 1'b1;
                n_state = lif_pkg::ST_IDLE;
            end
            default: n_state = lif_pkg::ST_IDLE;
        endcase
    end

    assign o_busy = (r_state != lif_pkg::ST_IDLE);

endmodule

`default_nettype wire

### rtl/lif_dp.sv
// Datapath of the LIF network engine: config registers, neuron and synapse
// memories, delay lines, multipliers and the result register. Uses lif_pkg.
`default_nettype none

module lif_dp #(
    parameter int MAX_NEURONS  = lif_pkg::MAX_NEURONS_DEF,
    parameter int MAX_SYNAPSES = lif_pkg::MAX_SYNAPSES_DEF,
    parameter int MAX_DELAY    = lif_pkg::MAX_DELAY_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_idx,
    input  wire logic [15:0]        i_cfg_data,
    input  wire logic [1:0]         i_action,
    input  wire logic [7:0]         i_index,
    input  wire logic signed [23:0] i_rest_level,
    input  wire logic signed [23:0] i_fire_level,
    input  wire logic [15:0]        i_leak_coeff,
    input  wire logic               i_is_inhibitory,
    input  wire logic [5:0]         i_from_neuron,
    input  wire logic [5:0]         i_to_neuron,
    input  wire logic signed [23:0] i_syn_weight,
    input  wire logic [4:0]         i_syn_delay,
    input  wire logic signed [23:0] i_stimulus,
    input  lif_pkg::t_cmd           i_cmd,
    output lif_pkg::t_status        o_status,
    output logic [63:0]             o_spike_mask,
    output logic                    o_valid,
    output logic                    o_tick_done
);

    localparam int NW    = $clog2(MAX_NEURONS);
    localparam int SW    = (MAX_SYNAPSES > 1) ? $clog2(MAX_SYNAPSES) : 1;
    localparam int DW    = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
    localparam int CLR_N = (MAX_SYNAPSES > MAX_NEURONS) ? MAX_SYNAPSES : MAX_NEURONS;
    localparam int CW    = $clog2(CLR_N + 1);
    localparam int SYNW  = 12 + 24 + DW;

    // config
    logic [6:0]  r_nc;
    logic [8:0]  r_sc;
    logic [15:0] r_dt;
    logic [7:0]  r_rt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nc <= lif_pkg::RST_NEURON_COUNT;
            r_sc <= lif_pkg::RST_SYNAPSE_COUNT;
            r_dt <= lif_pkg::RST_TICK_SCALE;
            r_rt <= lif_pkg::RST_REFRACT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lif_pkg::CFG_NEURON_COUNT:  r_nc <= i_cfg_data[6:0];
                lif_pkg::CFG_SYNAPSE_COUNT: r_sc <= i_cfg_data[8:0];
                lif_pkg::CFG_TICK_SCALE:    r_dt <= i_cfg_data;
                lif_pkg::CFG_REFRACT:       r_rt <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    logic [CW-1:0] nc_eff, sc_eff;
    assign nc_eff = (32'(r_nc) > MAX_NEURONS)  ? CW'(MAX_NEURONS)  : CW'(r_nc);
    assign sc_eff = (32'(r_sc) > MAX_SYNAPSES) ? CW'(MAX_SYNAPSES) : CW'(r_sc);

    logic [CW-1:0] r_cnt;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)          r_cnt <= '0;
        else if (i_cmd.cnt_rst) r_cnt <= '0;
        else if (i_cmd.cnt_inc) r_cnt <= r_cnt + CW'(1);
    end

    assign o_status.clr_last = (r_cnt == CW'(CLR_N - 1));
    assign o_status.syn_none = (sc_eff == '0);
    assign o_status.syn_last = ((r_cnt + CW'(1)) == sc_eff);
    assign o_status.nrn_none = (nc_eff == '0);
    assign o_status.nrn_last = ((r_cnt + CW'(1)) == nc_eff);

    logic [SW-1:0] s_idx;
    logic [NW-1:0] n_idx;
    assign s_idx = r_cnt[SW-1:0];
    assign n_idx = r_cnt[NW-1:0];

    // item decode
    lif_pkg::t_action act;
    logic wr_nrn, wr_syn, wr_stim;
    logic [NW-1:0] in_nidx;
    logic [SW-1:0] in_sidx;
    logic [DW-1:0] in_dly;
    assign act     = lif_pkg::t_action'(i_action);
    assign wr_nrn  = i_cmd.item_acc && act == lif_pkg::ACT_NEURON  && 32'(i_index) < MAX_NEURONS;
    assign wr_syn  = i_cmd.item_acc && act == lif_pkg::ACT_SYNAPSE && 32'(i_index) < MAX_SYNAPSES;
    assign wr_stim = i_cmd.item_acc && act == lif_pkg::ACT_STIM    && 32'(i_index) < MAX_NEURONS;
    assign in_nidx = i_index[NW-1:0];
    assign in_sidx = SW'(i_index);
    assign in_dly  = (32'(i_syn_delay) >= MAX_DELAY) ? DW'(MAX_DELAY - 1) : DW'(i_syn_delay);

    // synapse table
    logic [SYNW-1:0] syn_mem [MAX_SYNAPSES];
    logic [SYNW-1:0] r_syn;
    always_ff @(posedge i_clk) begin
        if (wr_syn) syn_mem[in_sidx] <= {i_from_neuron, i_to_neuron, i_syn_weight, in_dly};
        if (i_cmd.syn_rd) r_syn <= syn_mem[s_idx];
    end

    logic [5:0]          syn_src, syn_dst;
    logic signed [23:0]  syn_w;
    logic [DW-1:0]       syn_d;
    logic                syn_inert;
    assign {syn_src, syn_dst, syn_w, syn_d} = r_syn;
    assign syn_inert = (32'(syn_src) >= MAX_NEURONS) || (32'(syn_dst) >= MAX_NEURONS);

    logic [MAX_NEURONS-1:0] r_fired;
    logic [MAX_NEURONS-1:0] r_cs_vld;

    // delay lines
    logic [MAX_DELAY-1:0] dly_mem [MAX_SYNAPSES];
    logic [MAX_DELAY-1:0] r_line, line;
    logic                 r_src_fire, r_inh;
    assign line = r_line | (r_src_fire ? (MAX_DELAY'(1) << syn_d) : '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            if (32'(r_cnt) < MAX_SYNAPSES) dly_mem[s_idx] <= '0;
        end else if (wr_syn) begin
            dly_mem[in_sidx] <= '0;
        end else if (i_cmd.syn_upd && !syn_inert) begin
            dly_mem[s_idx] <= line >> 1;
        end
        if (i_cmd.syn_fetch) begin
            r_line     <= dly_mem[s_idx];
            r_src_fire <= (32'(syn_src) < 32'(nc_eff)) && r_fired[syn_src[NW-1:0]];
        end
    end

    // neuron memories
    logic        inh_mem  [MAX_NEURONS];
    logic [23:0] rest_mem [MAX_NEURONS];
    logic [23:0] thr_mem  [MAX_NEURONS];
    logic [15:0] leak_mem [MAX_NEURONS];
    logic [23:0] pot_mem  [MAX_NEURONS];
    logic [23:0] stim_mem [MAX_NEURONS];
    logic [7:0]  refr_mem [MAX_NEURONS];
    logic [23:0] cs_mem   [MAX_NEURONS];

    logic signed [23:0] r_rest, r_thr, r_pot, r_stim, r_cs;
    logic [15:0]        r_leak;
    logic [7:0]         r_refr;
    logic               r_cs_v;

    always_ff @(posedge i_clk) begin
        if (wr_nrn) begin
            inh_mem[in_nidx]  <= i_is_inhibitory;
            rest_mem[in_nidx] <= i_rest_level;
            thr_mem[in_nidx]  <= i_fire_level;
            leak_mem[in_nidx] <= i_leak_coeff;
        end
        if (i_cmd.syn_fetch) r_inh <= inh_mem[syn_src[NW-1:0]];
        if (i_cmd.nrn_rd) begin
            r_rest <= rest_mem[n_idx];
            r_thr  <= thr_mem[n_idx];
            r_leak <= leak_mem[n_idx];
        end
    end

    // synapse accumulate
    logic signed [24:0] w_signed;
    logic signed [23:0] cs_old, cs_new;
    assign w_signed = r_inh ? -25'(syn_w) : 25'(syn_w);
    assign cs_old   = r_cs_v ? r_cs : '0;
    assign cs_new   = lif_pkg::sat24(40'(cs_old) + 40'(w_signed));

    always_ff @(posedge i_clk) begin
        if (i_cmd.syn_upd && !syn_inert && line[0]) cs_mem[syn_dst[NW-1:0]] <= cs_new;
        if (i_cmd.syn_fetch) begin
            r_cs   <= cs_mem[syn_dst[NW-1:0]];
            r_cs_v <= r_cs_vld[syn_dst[NW-1:0]];
        end else if (i_cmd.nrn_rd) begin
            r_cs   <= cs_mem[n_idx];
            r_cs_v <= r_cs_vld[n_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.tick_begin) r_cs_vld <= '0;
        else if (i_cmd.syn_upd && !syn_inert && line[0]) r_cs_vld[syn_dst[NW-1:0]] <= 1'b1;
    end

    // neuron update
    logic signed [41:0] r_p1;
    logic signed [40:0] r_p3;
    logic signed [58:0] r_p2;
    logic signed [24:0] diff;
    assign diff = 25'(r_rest) - 25'(r_pot);

    always_ff @(posedge i_clk) begin
        if (i_cmd.nrn_mul1) begin
            r_p1 <= 42'(diff) * 42'(signed'({1'b0, r_leak}));
            r_p3 <= 41'(r_stim) * 41'(signed'({1'b0, r_dt}));
        end
        if (i_cmd.nrn_mul2) r_p2 <= 59'(r_p1) * 59'(signed'({1'b0, r_dt}));
    end

    logic signed [34:0] leak_v;
    logic signed [24:0] drive_v;
    logic signed [23:0] pot_new;
    logic               fire, refr_busy;
    assign leak_v    = r_p2[58:24];
    assign drive_v   = r_p3[40:16];
    assign pot_new   = lif_pkg::sat24(40'(r_pot) + 40'(leak_v) + 40'(cs_old) + 40'(drive_v));
    assign refr_busy = (r_refr != '0);
    assign fire      = !refr_busy && (pot_new >= r_thr);

    always_ff @(posedge i_clk) begin
        if (wr_nrn)                      pot_mem[in_nidx] <= i_rest_level;
        else if (i_cmd.nrn_upd && !refr_busy) pot_mem[n_idx] <= fire ? r_rest : pot_new;
        if (i_cmd.nrn_rd) r_pot <= pot_mem[n_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            if (32'(r_cnt) < MAX_NEURONS) stim_mem[n_idx] <= '0;
        end else if (wr_stim) begin
            stim_mem[in_nidx] <= i_stimulus;
        end else if (i_cmd.nrn_upd && !refr_busy) begin
            stim_mem[n_idx] <= '0;
        end
        if (i_cmd.nrn_rd) r_stim <= stim_mem[n_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            if (32'(r_cnt) < MAX_NEURONS) refr_mem[n_idx] <= '0;
        end else if (wr_nrn) begin
            refr_mem[in_nidx] <= '0;
        end else if (i_cmd.nrn_upd) begin
            refr_mem[n_idx] <= refr_busy ? r_refr - 8'd1 : (fire ? r_rt : 8'd0);
        end
        if (i_cmd.nrn_rd) r_refr <= refr_mem[n_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.fired_clr) r_fired <= '0;
        else if (wr_nrn)                 r_fired[in_nidx] <= 1'b0;
        else if (i_cmd.nrn_upd && fire)  r_fired[n_idx] <= 1'b1;
    end

    // result word
    logic r_valid, r_tick;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tick  <= 1'b0;
        end else begin
            r_valid <= i_cmd.res_item | i_cmd.res_tick;
            r_tick  <= i_cmd.res_tick;
        end
    end

    assign o_valid      = r_valid;
    assign o_tick_done  = r_tick;
    assign o_spike_mask = 64'(r_fired);

endmodule

`default_nettype wire

### tb/tb_lif_spiking_network_tick.sv
// Self-checking testbench for lif_spiking_network_tick: command words, register phases,
// built-in network predictor, a result monitor and randomised gaps between words.
// Depends on lif_pkg and the engine RTL only.
`timescale 1ns / 1ps

module tb_lif_spiking_network_tick;

    typedef struct {
        lif_pkg::t_action   act;
        logic [7:0]         idx;
        logic signed [23:0] rest;
        logic signed [23:0] fire;
        logic [15:0]        leak;
        logic               inh;
        logic [5:0]         src;
        logic [5:0]         dst;
        logic signed [23:0] wgt;
        logic [4:0]         dly;
        logic signed [23:0] stim;
    } t_word;

    typedef struct {
        logic [63:0] mask;
        logic        tick;
    } t_spikes;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_start = 1'b0;
    logic               o_busy;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_idx = '0;
    logic [15:0]        i_cfg_data = '0;
    logic [1:0]         i_action = '0;
    logic [7:0]         i_index = '0;
    logic signed [23:0] i_rest_level = '0;
    logic signed [23:0] i_fire_level = '0;
    logic [15:0]        i_leak_coeff = '0;
    logic               i_is_inhibitory = 1'b0;
    logic [5:0]         i_from_neuron = '0;
    logic [5:0]         i_to_neuron = '0;
    logic signed [23:0] i_syn_weight = '0;
    logic [4:0]         i_syn_delay = '0;
    logic signed [23:0] i_stimulus = '0;
    logic               o_valid;
    logic [63:0]        o_spike_mask;
    logic               o_tick_done;

    lif_spiking_network_tick uut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // network mirror
    logic [6:0]         n_neurons = lif_pkg::RST_NEURON_COUNT;
    logic [8:0]         n_synapses = lif_pkg::RST_SYNAPSE_COUNT;
    logic [15:0]        dt_scale = lif_pkg::RST_TICK_SCALE;
    logic [7:0]         refract_len = lif_pkg::RST_REFRACT;
    logic signed [23:0] pot [64];
    logic signed [23:0] rest_v [64];
    logic signed [23:0] thr_v [64];
    logic [15:0]        leak_v [64];
    logic               inh_v [64];
    logic [7:0]         refr_left [64];
    logic signed [23:0] stim_hold [64];
    logic signed [23:0] cur_sum [64];
    logic [63:0]        fired_now = '0;
    logic [5:0]         syn_src [256];
    logic [5:0]         syn_dst [256];
    logic signed [23:0] syn_w [256];
    logic [4:0]         syn_dly [256];
    logic [31:0]        in_flight [256];

    t_word   pending[$];
    t_spikes spikes_due[$];
    int      errors = 0;
    int      gap_left = 0;
    bit      no_gaps = 0;

    initial begin
        for (int i = 0; i < 64; i++) begin
            refr_left[i] = '0;
            stim_hold[i] = '0;
        end
        for (int i = 0; i < 256; i++) in_flight[i] = '0;
    end

    function automatic logic signed [23:0] clamp24(input longint x);
        if (x > 64'sd8388607) return 24'sh7fffff;
        if (x < -64'sd8388608) return 24'sh800000;
        return x[23:0];
    endfunction

    function automatic void network_tick();
        int nc, sc;
        logic [31:0] line;
        longint w, diff, lk, ts, drive, v;
        nc = (n_neurons > 64) ? 64 : n_neurons;
        sc = (n_synapses > 256) ? 256 : n_synapses;
        ts = dt_scale;
        for (int i = 0; i < 64; i++) cur_sum[i] = '0;
        for (int s = 0; s < sc; s++) begin
            line = in_flight[s];
            if (syn_src[s] < nc && fired_now[syn_src[s]]) line[syn_dly[s]] = 1'b1;
            if (line[0]) begin
                w = syn_w[s];
                if (inh_v[syn_src[s]]) w = -w;
                cur_sum[syn_dst[s]] = clamp24(longint'(cur_sum[syn_dst[s]]) + w);
            end
            in_flight[s] = line >> 1;
        end
        for (int i = 0; i < 64; i++) begin
            fired_now[i] = 1'b0;
            if (i < nc) begin
                if (refr_left[i] != 0) begin
                    refr_left[i] = refr_left[i] - 8'd1;
                end else begin
                    diff  = longint'(rest_v[i]) - longint'(pot[i]);
                    lk    = leak_v[i];
                    lk    = (diff * lk * ts) >>> 24;
                    drive = (longint'(stim_hold[i]) * ts) >>> 16;
                    v     = longint'(pot[i]) + lk + longint'(cur_sum[i]) + drive;
                    pot[i] = clamp24(v);
                    stim_hold[i] = '0;
                    if (pot[i] >= thr_v[i]) begin
                        fired_now[i] = 1'b1;
                        pot[i] = rest_v[i];
                        refr_left[i] = refract_len;
                    end
                end
            end
        end
    endfunction

    function automatic t_spikes apply_word(input t_word wd);
        t_spikes r;
        case (wd.act)
            lif_pkg::ACT_NEURON: if (wd.idx < 64) begin
                rest_v[wd.idx] = wd.rest;
                thr_v[wd.idx]  = wd.fire;
                leak_v[wd.idx] = wd.leak;
                inh_v[wd.idx]  = wd.inh;
                pot[wd.idx]    = wd.rest;
                refr_left[wd.idx] = '0;
                fired_now[wd.idx] = 1'b0;
            end
            lif_pkg::ACT_SYNAPSE: begin
                syn_src[wd.idx] = wd.src;
                syn_dst[wd.idx] = wd.dst;
                syn_w[wd.idx]   = wd.wgt;
                syn_dly[wd.idx] = wd.dly;
                in_flight[wd.idx] = '0;
            end
            lif_pkg::ACT_STIM: if (wd.idx < 64) stim_hold[wd.idx] = wd.stim;
            default: network_tick();
        endcase
        r.mask = fired_now;
        r.tick = (wd.act == lif_pkg::ACT_TICK);
        return r;
    endfunction

    // mostly modest Q11.12 values so neurons actually cross threshold
    function automatic logic signed [23:0] rand_q(input int span);
        if ($urandom_range(0, 9) == 0) return 24'($urandom());
        return 24'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic t_word rand_word();
        t_word wd;
        int pick;
        wd = '{act: lif_pkg::ACT_TICK, idx: '0, rest: rand_q(16384), fire: '0,
               leak: 16'($urandom()), inh: ($urandom_range(0, 3) == 0),
               src: 6'($urandom()), dst: 6'($urandom()), wgt: rand_q(32768),
               dly: 5'($urandom()), stim: '0};
        wd.fire = ($urandom_range(0, 9) == 0) ? 24'($urandom())
                  : clamp24(longint'(wd.rest) + $urandom_range(0, 12000));
        wd.stim = ($urandom_range(0, 1) == 0) ? rand_q(8388607) : rand_q(1 << 22);
        if ($urandom_range(0, 7) == 0) wd.dly = 5'($urandom_range(0, 3));
        pick = $urandom_range(0, 99);
        if (pick < 14) begin
            wd.act = lif_pkg::ACT_NEURON;
            wd.idx = ($urandom_range(0, 15) == 0) ? 8'($urandom())
                                                   : 8'($urandom_range(0, 63));
        end else if (pick < 30) begin
            wd.act = lif_pkg::ACT_SYNAPSE;
            wd.idx = 8'($urandom());
        end else if (pick < 70) begin
            wd.act = lif_pkg::ACT_STIM;
            wd.idx = ($urandom_range(0, 15) == 0) ? 8'($urandom())
                                                   : 8'($urandom_range(0, 63));
        end
        return wd;
    endfunction

    // driver
    always @(posedge i_clk) begin
        t_word wd;
        if (i_start && !o_busy)
            spikes_due.push_back(apply_word(t_word'{act: lif_pkg::t_action'(i_action),
                idx: i_index, rest: i_rest_level, fire: i_fire_level, leak: i_leak_coeff,
                inh: i_is_inhibitory, src: i_from_neuron, dst: i_to_neuron,
                wgt: i_syn_weight, dly: i_syn_delay, stim: i_stimulus}));
        if (i_start && o_busy) begin
            // held until taken
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            i_start <= 1'b0;
        end else if (pending.size() != 0) begin
            wd = pending.pop_front();
            i_action <= wd.act;
            i_index <= wd.idx;
            i_rest_level <= wd.rest;
            i_fire_level <= wd.fire;
            i_leak_coeff <= wd.leak;
            i_is_inhibitory <= wd.inh;
            i_from_neuron <= wd.src;
            i_to_neuron <= wd.dst;
            i_syn_weight <= wd.wgt;
            i_syn_delay <= wd.dly;
            i_stimulus <= wd.stim;
            i_start <= 1'b1;
            if (!no_gaps && $urandom_range(0, 2) == 0)
                gap_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60)
                                                         : $urandom_range(1, 3);
        end else begin
            i_start <= 1'b0;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_spikes e;
        if (i_rst_n && o_valid) begin
            if (spikes_due.size() == 0) begin
                $error("result word with nothing expected: mask %h", o_spike_mask);
                errors++;
            end else begin
                e = spikes_due.pop_front();
                if (o_spike_mask !== e.mask) begin
                    $error("spike_mask: expected %h, got %h", e.mask, o_spike_mask);
                    errors++;
                end
                if (o_tick_done !== e.tick) begin
                    $error("tick_done: expected %b, got %b", e.tick, o_tick_done);
                    errors++;
                end
            end
        end
    end

    task automatic drain();
        wait (pending.size() == 0 && !i_start && spikes_due.size() == 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_regs(input logic [15:0] nc, input logic [15:0] sc,
                            input logic [15:0] ts, input logic [15:0] rf);
        logic [15:0] vals [4];
        vals = '{nc, sc, ts, rf};
        for (int r = 0; r < 4; r++) begin
            @(posedge i_clk);
            i_cfg_we <= 1'b1;
            i_cfg_idx <= r[1:0];
            i_cfg_data <= vals[r];
            case (r[1:0])
                lif_pkg::CFG_NEURON_COUNT:  n_neurons = vals[r][6:0];
                lif_pkg::CFG_SYNAPSE_COUNT: n_synapses = vals[r][8:0];
                lif_pkg::CFG_TICK_SCALE:    dt_scale = vals[r];
                default:                    refract_len = vals[r][7:0];
            endcase
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic add_ticks(input int n);
        t_word wd;
        for (int k = 0; k < n; k++) begin
            wd = rand_word();
            wd.act = lif_pkg::ACT_TICK;
            pending.push_back(wd);
        end
    endtask

    initial begin
        t_word wd;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every neuron and synapse entry defined before any tick reads it
        for (int i = 0; i < 64; i++) begin
            wd = rand_word();
            wd.act = lif_pkg::ACT_NEURON;
            wd.idx = 8'(i);
            pending.push_back(wd);
        end
        for (int i = 0; i < 256; i++) begin
            wd = rand_word();
            wd.act = lif_pkg::ACT_SYNAPSE;
            wd.idx = 8'(i);
            pending.push_back(wd);
        end
        // directed: extremes and ignored indexes
        wd = rand_word();
        wd.act = lif_pkg::ACT_NEURON; wd.idx = 8'd3; wd.rest = 24'sh800000;
        wd.fire = 24'sh7fffff; wd.leak = 16'hffff; wd.inh = 1'b1;
        pending.push_back(wd);
        wd.idx = 8'd255; pending.push_back(wd);
        wd.act = lif_pkg::ACT_STIM; wd.idx = 8'd3; wd.stim = 24'sh7fffff;
        pending.push_back(wd);
        wd.idx = 8'd4; wd.stim = 24'sh800000; pending.push_back(wd);
        wd.idx = 8'd200; pending.push_back(wd);
        wd.act = lif_pkg::ACT_SYNAPSE; wd.idx = 8'd0; wd.src = 6'd5; wd.dst = 6'd63;
        wd.wgt = 24'sh7fffff; wd.dly = 5'd31; pending.push_back(wd);
        wd.idx = 8'd1; wd.src = 6'd63; wd.dst = 6'd5; wd.wgt = 24'sh800000;
        wd.dly = 5'd0; pending.push_back(wd);
        add_ticks(4);
        drain();

        set_regs(16'd64, 16'd256, 16'd655, 16'd10);
        for (int k = 0; k < 300; k++) pending.push_back(rand_word());
        drain();
        set_regs(16'd127, 16'd511, 16'hffff, 16'd0);
        no_gaps = 1;
        for (int k = 0; k < 250; k++) pending.push_back(rand_word());
        drain();
        no_gaps = 0;
        set_regs(16'd1, 16'd8, 16'd0, 16'd255);
        for (int k = 0; k < 150; k++) pending.push_back(rand_word());
        drain();
        set_regs(16'd0, 16'd40, 16'd30000, 16'd3);
        for (int k = 0; k < 100; k++) pending.push_back(rand_word());
        drain();
        set_regs(16'd48, 16'd64, 16'd20000, 16'd1);
        for (int k = 0; k < 270; k++) pending.push_back(rand_word());
        drain();
        set_regs(16'd64, 16'd128, 16'd45000, 16'd2);
        for (int k = 0; k < 400; k++) pending.push_back(rand_word());
        drain();

        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("tb_lif_spiking_network_tick: done, clean");
        else
            $display("tb_lif_spiking_network_tick: done, errors");
        $finish;
    end

    initial begin
        #200_000_000;
        $display("tb_lif_spiking_network_tick: done, errors");
        $finish;
    end

endmodule
